[src/fisher_yates_shuffle_engine_defines.svh]
// assertion macros shared by the shuffle engine rtl
`ifndef FISHER_YATES_SHUFFLE_ENGINE_DEFINES_SVH
`define FISHER_YATES_SHUFFLE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FYS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fys assertion failed");
// next-cycle implication
`define FYS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fys assertion failed");
`else
`define FYS_ASSERT_NOW(label, clk, rst, ante, cons)
`define FYS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[src/fys_pkg.sv]
package fys_pkg;

   localparam int GEN_W     = 16;
   localparam int VALUE_W   = 8;
   localparam int SEED_W    = 32;
   localparam int KIND_W    = 2;
   localparam int PROD_W    = 2 * GEN_W;

   localparam int CAPACITY_DEF   = 64;
   localparam int ITEM_WIDTH_DEF = 8;

   localparam logic [KIND_W-1:0] KIND_APPEND  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SHUFFLE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESEED  = 2'd2;

   localparam logic [GEN_W-1:0]  GEN_RESET    = 16'd12345;
   localparam logic [SEED_W-1:0] SEED_MULT    = 32'd2654435761;
   // only the low half of the seed product survives truncation
   localparam logic [GEN_W-1:0]  SEED_MULT_LO = SEED_MULT[GEN_W-1:0];

   // xorshift step, shifts 7, 9, 8
   function automatic logic [GEN_W-1:0] gen_advance(input logic [GEN_W-1:0] w);
      logic [GEN_W-1:0] a;
      logic [GEN_W-1:0] b;
      a = w ^ (w << 7);
      b = a ^ (a >> 9);
      return b ^ (b << 8);
   endfunction

endpackage

[src/fys_ram.sv]
module fys_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/fys_mul.sv]
module fys_mul (
   input  logic                         clock,
   input  logic [fys_pkg::GEN_W-1:0]    op_a,
   input  logic [fys_pkg::GEN_W-1:0]    op_b,
   output logic [fys_pkg::PROD_W-1:0]   prod
);

   // shared 16x16 multiplier, product registered
   logic [fys_pkg::PROD_W-1:0] prod_ff;
   logic [fys_pkg::PROD_W-1:0] prod_in;

   assign prod_in = {{fys_pkg::GEN_W{1'b0}}, op_a} * {{fys_pkg::GEN_W{1'b0}}, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

[src/fisher_yates_shuffle_engine.sv]
// shuffle engine: collects items, shuffles them in place, reads them out
// input channel: a transaction is taken when start is high and busy is low;
//   req_kind selects append (req_item_value), shuffle, or reseed (req_seed_value)
// append and reseed give no result; append into a full store is dropped
// append leaves busy low; reseed holds busy for one cycle
// shuffle of n entries: n-1 swap steps, each walking advance, multiply, pick,
//   two writes through the store and the shared multiplier; then one store
//   read a cycle emits n results, and busy stays high through the last one
// results: rsp_valid strobes for one cycle per entry, index 0 first,
//   rsp_last on the final one; the receiver cannot stall, so results go out
//   back to back and the store is empty when busy drops
// an empty store gives no result and leaves the generator as it was
// reset: store count zero, generator 12345, no result pending; store
//   contents are not cleared since only written entries are ever read
module fisher_yates_shuffle_engine #(
   parameter int CAPACITY   = fys_pkg::CAPACITY_DEF,
   parameter int ITEM_WIDTH = fys_pkg::ITEM_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [fys_pkg::KIND_W-1:0]   req_kind,
   input  logic [fys_pkg::VALUE_W-1:0]  req_item_value,
   input  logic [fys_pkg::SEED_W-1:0]   req_seed_value,
   output logic                         rsp_valid,
   output logic [fys_pkg::VALUE_W-1:0]  rsp_out_value,
   output logic                         rsp_last
);

`include "fisher_yates_shuffle_engine_defines.svh"

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int GW    = fys_pkg::GEN_W;
   localparam int VW    = fys_pkg::VALUE_W;
   localparam int PW    = fys_pkg::PROD_W;

   // sequencer codes
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ADV   = 4'd1;  // step generator, read entry i
   localparam logic [3:0] S_MUL   = 4'd2;  // rnd * (i+1), latch entry i
   localparam logic [3:0] S_PICK  = 4'd3;  // j from product, read entry j
   localparam logic [3:0] S_WRI   = 4'd4;  // store[i] <= entry j
   localparam logic [3:0] S_WRJ   = 4'd5;  // store[j] <= old entry i
   localparam logic [3:0] S_EMIT  = 4'd6;  // read out one entry a cycle
   localparam logic [3:0] S_DRAIN = 4'd7;  // last read data on the ports
   localparam logic [3:0] S_SEED  = 4'd8;  // load generator from product

   logic [3:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [GW-1:0]         gen_ff, gen_in;
   logic [IDX_W-1:0]      i_ff, i_in;
   logic [IDX_W-1:0]      j_ff, j_in;
   logic [IDX_W-1:0]      k_ff, k_in;
   logic [ITEM_WIDTH-1:0] data_i_ff, data_i_in;
   logic                  emit_vld_ff, emit_vld_in;
   logic                  emit_last_ff, emit_last_in;

   logic                  accept;
   logic                  emit_at_end;
   logic [CNT_W-1:0]      last_idx;
   logic [GW-1:0]         j_raw;
   logic [IDX_W-1:0]      j_pick;
   logic [GW-1:0]         seed_mix;

   // store port
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [ITEM_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [ITEM_WIDTH-1:0] rd_data;

   // shared multiplier
   logic [GW-1:0]         mul_a;
   logic [GW-1:0]         mul_b;
   logic [PW-1:0]         prod;

   fys_ram #(
      .WIDTH (ITEM_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fys_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // multiplier operands: pick during a swap step, seed mix otherwise
   always_comb begin
      if (state_ff == S_MUL) begin
         mul_a = gen_ff;
         mul_b = GW'({1'b0, i_ff} + 1'b1);
      end else begin
         mul_a = req_seed_value[GW-1:0];
         mul_b = fys_pkg::SEED_MULT_LO;
      end
   end

   // j is the high half of rnd*(i+1), never above i
   assign j_raw  = prod[PW-1:GW];
   assign j_pick = (j_raw > GW'(i_ff)) ? i_ff : j_raw[IDX_W-1:0];

   // (seed*mult + 1) | 1 kept to 16 bits
   assign seed_mix = (prod[GW-1:0] + 1'b1) | GW'(1);

   assign last_idx    = count_ff - 1'b1;
   assign emit_at_end = (CNT_W'(k_ff) == last_idx);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      gen_in       = gen_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      data_i_in    = data_i_ff;
      emit_vld_in  = 1'b0;
      emit_last_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = i_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = i_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  fys_pkg::KIND_APPEND: begin
                     if (count_ff < CNT_W'(CAPACITY)) begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IDX_W-1:0];
                        wr_data  = ITEM_WIDTH'(req_item_value);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  fys_pkg::KIND_SHUFFLE: begin
                     if (count_ff == CNT_W'(1)) begin
                        k_in     = '0;
                        state_in = S_EMIT;
                     end else if (count_ff != '0) begin
                        i_in     = last_idx[IDX_W-1:0];
                        state_in = S_ADV;
                     end
                  end
                  fys_pkg::KIND_RESEED: begin
                     // product of the seed is registered this cycle
                     state_in = S_SEED;
                  end
                  default: begin
                     // unused kind: dropped
                  end
               endcase
            end
         end
         S_SEED: begin
            gen_in   = seed_mix;
            state_in = S_IDLE;
         end
         S_ADV: begin
            gen_in   = fys_pkg::gen_advance(gen_ff);
            rd_en    = 1'b1;
            rd_addr  = i_ff;
            state_in = S_MUL;
         end
         S_MUL: begin
            data_i_in = rd_data;
            state_in  = S_PICK;
         end
         S_PICK: begin
            j_in     = j_pick;
            rd_en    = 1'b1;
            rd_addr  = j_pick;
            state_in = S_WRI;
         end
         S_WRI: begin
            wr_en    = 1'b1;
            wr_addr  = i_ff;
            wr_data  = rd_data;
            state_in = S_WRJ;
         end
         S_WRJ: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = data_i_ff;
            if (i_ff == IDX_W'(1)) begin
               k_in     = '0;
               state_in = S_EMIT;
            end else begin
               i_in     = i_ff - 1'b1;
               state_in = S_ADV;
            end
         end
         S_EMIT: begin
            rd_en        = 1'b1;
            rd_addr      = k_ff;
            emit_vld_in  = 1'b1;
            emit_last_in = emit_at_end;
            if (emit_at_end) begin
               state_in = S_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            count_in = '0;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         gen_ff       <= fys_pkg::GEN_RESET;
         emit_vld_ff  <= 1'b0;
         emit_last_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         gen_ff       <= gen_in;
         emit_vld_ff  <= emit_vld_in;
         emit_last_ff <= emit_last_in;
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      data_i_ff <= data_i_in;
   end

   // results come straight from the store's read register
   assign rsp_valid     = emit_vld_ff;
   assign rsp_out_value = VW'(rd_data);
   assign rsp_last      = emit_vld_ff && emit_last_ff;

   // a result only appears inside a shuffle run
   `FYS_ASSERT_NOW(a_rsp_in_run, clock, reset, rsp_valid, busy)
   // the final result closes the run with an empty store
   `FYS_ASSERT_NEXT(a_last_ends_run, clock, reset, rsp_last, !busy && count_ff == '0)
   // fill level never passes the store depth
   `FYS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   // the swap partner never lies above the walking index
   `FYS_ASSERT_NOW(a_swap_order, clock, reset, state_ff == S_WRJ, j_ff <= i_ff)
   // xorshift state can never collapse to zero
   `FYS_ASSERT_NOW(a_gen_nonzero, clock, reset, 1'b1, gen_ff != '0)

endmodule

[tb/fisher_yates_shuffle_engine_checker.sv]
module fisher_yates_shuffle_engine_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [fys_pkg::KIND_W-1:0]   req_kind,
   input  logic [fys_pkg::VALUE_W-1:0]  req_item_value,
   input  logic [fys_pkg::SEED_W-1:0]   req_seed_value,
   input  logic                         rsp_valid,
   input  logic [fys_pkg::VALUE_W-1:0]  rsp_out_value,
   input  logic                         rsp_last,
   output int                           fail_count,
   output int                           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [fys_pkg::VALUE_W-1:0] value;
      logic                        last;
   } dealt_entry_type;

   // predicted copy of the engine state
   logic [fys_pkg::VALUE_W-1:0] deck [fys_pkg::CAPACITY_DEF];
   int                          deck_count = 0;
   logic [fys_pkg::GEN_W-1:0]   xs_word = fys_pkg::GEN_RESET;

   dealt_entry_type dealt_q [$];
   int              errors = 0;
   int              waiting = 0;

   assign fail_count  = errors;
   assign outstanding = waiting;

   function automatic logic [fys_pkg::GEN_W-1:0] xorshift_next(
      input logic [fys_pkg::GEN_W-1:0] w);
      logic [fys_pkg::GEN_W-1:0] t;
      t = w ^ (w << 7);
      t = t ^ (t >> 9);
      t = t ^ (t << 8);
      return t;
   endfunction

   function automatic logic [fys_pkg::GEN_W-1:0] mixed_seed(
      input logic [fys_pkg::SEED_W-1:0] s);
      logic [fys_pkg::SEED_W-1:0] m;
      m    = s * fys_pkg::SEED_MULT + 32'd1;
      m[0] = 1'b1;
      return m[fys_pkg::GEN_W-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $realtime, msg);
      errors++;
   endtask

   task automatic shuffle_and_deal();
      int unsigned                 i;
      int unsigned                 j;
      logic [31:0]                 prod;
      logic [fys_pkg::VALUE_W-1:0] tmp;
      dealt_entry_type             e;
      if (deck_count == 0) return;
      for (i = deck_count - 1; i > 0; i--) begin
         xs_word = xorshift_next(xs_word);
         prod    = 32'(xs_word) * 32'(i + 1);
         j       = prod[31:16];
         if (j > i) j = i;
         tmp     = deck[i];
         deck[i] = deck[j];
         deck[j] = tmp;
      end
      for (i = 0; i < deck_count; i++) begin
         e.value = deck[i];
         e.last  = (i + 1 == deck_count);
         dealt_q.push_back(e);
      end
      deck_count = 0;
   endtask

   always @(posedge clock) begin
      dealt_entry_type want;
      if (reset) begin
         deck_count = 0;
         xs_word    = fys_pkg::GEN_RESET;
         dealt_q.delete();
      end else begin
         if (rsp_valid) begin
            if (dealt_q.size() == 0) begin
               report_mismatch($sformatf("result %0h with nothing expected", rsp_out_value));
            end else begin
               want = dealt_q.pop_front();
               if (rsp_out_value !== want.value)
                  report_mismatch($sformatf("out_value expected %0h got %0h",
                                            want.value, rsp_out_value));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last expected %0b got %0b", want.last, rsp_last));
            end
         end
         if (start && !busy) begin
            case (req_kind)
               fys_pkg::KIND_APPEND: begin
                  if (deck_count < fys_pkg::CAPACITY_DEF) begin
                     deck[deck_count] = req_item_value;
                     deck_count++;
                  end
               end
               fys_pkg::KIND_SHUFFLE: shuffle_and_deal();
               fys_pkg::KIND_RESEED:  xs_word = mixed_seed(req_seed_value);
               default: ;
            endcase
         end
      end
      waiting = dealt_q.size();
   end

endmodule

[tb/fisher_yates_shuffle_engine_tb.sv]
module fisher_yates_shuffle_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // the block ignores this code; it is only sent as noise
   localparam logic [fys_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   // the limit covers the wait for the first result of a full 64-entry shuffle,
   // plus the longest sender gap, several times over
   localparam int STALL_LIMIT   = 3000;
   // random transactions on top of the directed ones
   localparam int RANDOM_ITEMS  = 140;
   localparam int SETTLE_CYCLES = 20;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [fys_pkg::KIND_W-1:0]   req_kind = fys_pkg::KIND_APPEND;
   logic [fys_pkg::VALUE_W-1:0]  req_item_value = '0;
   logic [fys_pkg::SEED_W-1:0]   req_seed_value = '0;
   logic                         rsp_valid;
   logic [fys_pkg::VALUE_W-1:0]  rsp_out_value;
   logic                         rsp_last;

   int fail_count;
   int outstanding;
   int burst_left = 0;
   int idle_cycles = 0;
   int sent_count = 0;

   always #2 clock = ~clock;

   fisher_yates_shuffle_engine dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_item_value (req_item_value),
      .req_seed_value (req_seed_value),
      .rsp_valid      (rsp_valid),
      .rsp_out_value  (rsp_out_value),
      .rsp_last       (rsp_last)
   );

   fisher_yates_shuffle_engine_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_item_value (req_item_value),
      .req_seed_value (req_seed_value),
      .rsp_valid      (rsp_valid),
      .rsp_out_value  (rsp_out_value),
      .rsp_last       (rsp_last),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   // watchdog: any accepted transaction or result counts as progress
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // issue one transaction; called at a falling edge, returns at the falling edge
   // after acceptance, or after the gap ending a burst; start stays high in a burst
   task automatic send_item(input logic [fys_pkg::KIND_W-1:0] k,
                            input logic [fys_pkg::VALUE_W-1:0] v,
                            input logic [fys_pkg::SEED_W-1:0] s);
      int gap;
      start          <= 1'b1;
      req_kind       <= k;
      req_item_value <= v;
      req_seed_value <= s;
      // busy only moves at rising edges, so its value here is what the next edge sees
      while (busy) @(negedge clock);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         // burst over: random gap, then pick the next burst length
         gap = $urandom_range(1, 12);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
         // long bursts now and then give stretches with no idling at all
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // hold the sender off until every predicted result has come out
   task automatic drain_results();
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   // one well-formed hand: optional reseed, a run of appends, a shuffle;
   // some hands are broken up by noise or a shuffle of an empty store
   task automatic play_hand(input int hand_size);
      int n;
      if ($urandom_range(0, 4) == 0) begin
         send_item(fys_pkg::KIND_RESEED, fys_pkg::VALUE_W'($urandom()), $urandom());
         sent_count++;
      end
      for (n = 0; n < hand_size; n++) begin
         if ($urandom_range(0, 15) == 0)
            send_item(KIND_UNUSED, fys_pkg::VALUE_W'($urandom()), $urandom());
         if ($urandom_range(0, 20) == 0) begin
            // reseed in the middle of loading
            send_item(fys_pkg::KIND_RESEED, fys_pkg::VALUE_W'($urandom()), $urandom());
            sent_count++;
         end
         send_item(fys_pkg::KIND_APPEND, fys_pkg::VALUE_W'($urandom_range(0, 255)),
                   $urandom());
         sent_count++;
      end
      send_item(fys_pkg::KIND_SHUFFLE, fys_pkg::VALUE_W'($urandom()), $urandom());
      sent_count++;
      // a second shuffle hits an empty store
      if ($urandom_range(0, 7) == 0) begin
         send_item(fys_pkg::KIND_SHUFFLE, fys_pkg::VALUE_W'($urandom()), $urandom());
         sent_count++;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: shuffle of an empty store must not touch the generator
      send_item(fys_pkg::KIND_SHUFFLE, 8'h00, 32'h0);
      // single entry: no generator step, emitted with last set
      send_item(fys_pkg::KIND_APPEND, 8'h00, 32'h0);
      send_item(fys_pkg::KIND_SHUFFLE, 8'h00, 32'h0);
      // two entries, field extremes
      send_item(fys_pkg::KIND_APPEND, 8'hFF, 32'hFFFF_FFFF);
      send_item(fys_pkg::KIND_APPEND, 8'h01, 32'h0);
      send_item(fys_pkg::KIND_SHUFFLE, 8'hFF, 32'hFFFF_FFFF);
      // unused kind is ignored
      send_item(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF);
      // reseed with zero seed, then a four-entry hand
      send_item(fys_pkg::KIND_RESEED, 8'h00, 32'h0);
      send_item(fys_pkg::KIND_APPEND, 8'h80, 32'h0);
      send_item(fys_pkg::KIND_APPEND, 8'h7F, 32'h0);
      send_item(fys_pkg::KIND_APPEND, 8'h55, 32'h0);
      send_item(fys_pkg::KIND_APPEND, 8'hAA, 32'h0);
      send_item(fys_pkg::KIND_SHUFFLE, 8'h00, 32'h0);
      // reseed with all-ones seed
      send_item(fys_pkg::KIND_RESEED, 8'h00, 32'hFFFF_FFFF);
      send_item(fys_pkg::KIND_APPEND, 8'h12, 32'h0);
      send_item(fys_pkg::KIND_APPEND, 8'h34, 32'h0);
      send_item(fys_pkg::KIND_APPEND, 8'h56, 32'h0);
      send_item(fys_pkg::KIND_SHUFFLE, 8'h00, 32'h0);
      send_item(fys_pkg::KIND_RESEED, 8'h00, 32'h8000_0001);
      drain_results();

      // first random hand overfills the store so appends into a full store get dropped
      play_hand(66);
      drain_results();
      while (sent_count < RANDOM_ITEMS) begin
         // most hands small, a rare one near or past capacity
         play_hand(($urandom_range(0, 11) == 0) ? $urandom_range(60, 70)
                                                : $urandom_range(1, 9));
         if ($urandom_range(0, 3) == 0) drain_results();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/fys_pkg.sv
src/fys_ram.sv
src/fys_mul.sv
src/fisher_yates_shuffle_engine.sv
tb/fisher_yates_shuffle_engine_checker.sv
tb/fisher_yates_shuffle_engine_tb.sv
